[design/cordic_sine_cosine_unit_macros.svh]
// -----------------------------------------------------------------------------
// cordic_sine_cosine_unit_macros.svh
// Assertion helpers for the CORDIC sine/cosine unit. They expect clk and rst_n
// to be in scope.
// -----------------------------------------------------------------------------
`ifndef CORDIC_SINE_COSINE_UNIT_MACROS_SVH
`define CORDIC_SINE_COSINE_UNIT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CSC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define CSC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

[design/csc_pkg.sv]
// -----------------------------------------------------------------------------
// csc_pkg
// Shared widths, arctangent table and stage types for the CORDIC unit.
// -----------------------------------------------------------------------------
package csc_pkg;

  localparam int CSC_ROTATION_STEPS = 16;
  localparam int CSC_TABLE_LEN      = 16;

  localparam int CSC_PHASE_W = 16;
  localparam int CSC_RES_W   = 14;          // residual angle bits
  localparam int CSC_OUT_W   = 17;
  localparam int CSC_XY_W    = 33;          // x/y datapath, |x|,|y| < 2^31
  localparam int CSC_Z_W     = 34;          // angle accumulator
  localparam int CSC_ATAN_W  = 32;
  localparam int CSC_MAG_W   = CSC_XY_W - 14;  // |v| >> 14
  localparam int CSC_GAIN_W  = 15;
  localparam int CSC_PROD_W  = CSC_MAG_W + CSC_GAIN_W;

  localparam logic [CSC_GAIN_W-1:0] CSC_GAIN = 15'h4DBA;
  localparam logic signed [CSC_XY_W-1:0] CSC_X_START = CSC_XY_W'(64'sd1 <<< 30);

  // atan(2^-i), 2^31 = 90 degrees
  localparam logic [CSC_ATAN_W-1:0] CSC_ATAN [CSC_TABLE_LEN] = '{
    32'h40000000, 32'h25C80A3B, 32'h13F670B7, 32'h0A2223A8,
    32'h05161A86, 32'h028BAFC3, 32'h0145EC3D, 32'h00A2F8AA,
    32'h00517CA7, 32'h0028BE5D, 32'h00145F30, 32'h000A2F98,
    32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA
  };

  typedef enum logic [1:0] {
    CSC_QUAD_0 = 2'd0,
    CSC_QUAD_1 = 2'd1,
    CSC_QUAD_2 = 2'd2,
    CSC_QUAD_3 = 2'd3
  } csc_quad_t;

  typedef struct packed {
    csc_quad_t                   quad;
    logic signed [CSC_XY_W-1:0]  x;
    logic signed [CSC_XY_W-1:0]  y;
    logic signed [CSC_Z_W-1:0]   z;
  } csc_stage_t;

endpackage

[design/csc_rot_stage.sv]
// -----------------------------------------------------------------------------
// csc_rot_stage
// One registered rotation-mode CORDIC micro-rotation with a fixed shift.
// -----------------------------------------------------------------------------
module csc_rot_stage
  import csc_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       vld_i,
  input  csc_stage_t stg_i,
  output logic       vld_o,
  output csc_stage_t stg_o
);

  localparam logic signed [CSC_Z_W-1:0] ATAN_EXT =
    $signed({{(CSC_Z_W-CSC_ATAN_W){1'b0}}, CSC_ATAN[STEP]});

  logic              vld_r;
  csc_stage_t        stg_r;
  csc_stage_t        stg_nxt;
  logic signed [CSC_XY_W-1:0] x_sh;
  logic signed [CSC_XY_W-1:0] y_sh;

  // arithmetic shift rounds toward minus infinity
  assign x_sh = stg_i.x >>> STEP;
  assign y_sh = stg_i.y >>> STEP;

  always_comb begin
    stg_nxt.quad = stg_i.quad;
    if (stg_i.z[CSC_Z_W-1]) begin
      stg_nxt.z = stg_i.z + ATAN_EXT;
      stg_nxt.x = stg_i.x + y_sh;
      stg_nxt.y = stg_i.y - x_sh;
    end else begin
      stg_nxt.z = stg_i.z - ATAN_EXT;
      stg_nxt.x = stg_i.x - y_sh;
      stg_nxt.y = stg_i.y + x_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

  assign vld_o = vld_r;
  assign stg_o = stg_r;

endmodule

[design/csc_scale.sv]
// -----------------------------------------------------------------------------
// csc_scale
// Gain scaling of |x| and |y| and quadrant placement, two register stages.
// -----------------------------------------------------------------------------
module csc_scale
  import csc_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        vld_i,
  input  csc_stage_t                  stg_i,
  output logic                        vld_o,
  output logic signed [CSC_OUT_W-1:0] cosine_o,
  output logic signed [CSC_OUT_W-1:0] sine_o
);

  logic [CSC_XY_W-1:0]   abs_x;
  logic [CSC_XY_W-1:0]   abs_y;
  logic [CSC_PROD_W-1:0] prod_x_nxt, prod_y_nxt;
  logic [CSC_PROD_W-1:0] prod_x_r, prod_y_r;
  csc_quad_t             quad_r;
  logic                  vld1_r;

  logic [CSC_OUT_W-1:0]  mag_x, mag_y;
  logic signed [CSC_OUT_W-1:0] cos_nxt, sin_nxt;
  logic signed [CSC_OUT_W-1:0] cos_r, sin_r;
  logic                  vld2_r;

  // stage 1: magnitude and gain product
  always_comb begin
    abs_x = stg_i.x[CSC_XY_W-1] ? CSC_XY_W'(-stg_i.x) : CSC_XY_W'(stg_i.x);
    abs_y = stg_i.y[CSC_XY_W-1] ? CSC_XY_W'(-stg_i.y) : CSC_XY_W'(stg_i.y);
    prod_x_nxt = CSC_PROD_W'(abs_x[CSC_XY_W-1:14]) * CSC_PROD_W'(CSC_GAIN);
    prod_y_nxt = CSC_PROD_W'(abs_y[CSC_XY_W-1:14]) * CSC_PROD_W'(CSC_GAIN);
  end

  always_ff @(posedge clk) begin
    prod_x_r <= prod_x_nxt;
    prod_y_r <= prod_y_nxt;
    quad_r   <= stg_i.quad;
  end

  // stage 2: place and negate by quadrant
  assign mag_x = prod_x_r[16 +: CSC_OUT_W];
  assign mag_y = prod_y_r[16 +: CSC_OUT_W];

  always_comb begin
    case (quad_r)
      CSC_QUAD_0: begin
        cos_nxt = $signed(mag_x);
        sin_nxt = $signed(mag_y);
      end
      CSC_QUAD_1: begin
        cos_nxt = -$signed(mag_y);
        sin_nxt = $signed(mag_x);
      end
      CSC_QUAD_2: begin
        cos_nxt = -$signed(mag_x);
        sin_nxt = -$signed(mag_y);
      end
      default: begin
        cos_nxt = $signed(mag_y);
        sin_nxt = -$signed(mag_x);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cos_r <= cos_nxt;
    sin_r <= sin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  assign vld_o    = vld2_r;
  assign cosine_o = cos_r;
  assign sine_o   = sin_r;

endmodule

[design/cordic_sine_cosine_unit.sv]
// -----------------------------------------------------------------------------
// cordic_sine_cosine_unit
// Phase to cosine/sine converter, pipelined rotation-mode CORDIC.
// -----------------------------------------------------------------------------
// Usage:
//   Drive in_phase (65536 steps per turn) and pulse start; a beat is taken at
//   every clock edge with start high and busy low. busy is always low: the
//   pipeline takes one phase per clock with no gaps.
//   Each result beat shows on out_cosine/out_sine (signed Q1.15, 32768 = 1.0)
//   for exactly one cycle, marked by out_valid.
// Pipeline: from the accepting edge to the edge that takes the result, one
//   register per micro-rotation, then one for the gain multiply and one for
//   the quadrant mapping. Throughput: one beat per clock.
// Reset: synchronous, active low; clears the valid bits of every stage, so no
//   stale beat comes out after reset. Data registers are not reset.
// Back-pressure: none; the receiver must take each beat in its cycle.
// -----------------------------------------------------------------------------
`include "cordic_sine_cosine_unit_macros.svh"

module cordic_sine_cosine_unit
  import csc_pkg::*;
#(
  parameter int ROTATION_STEPS = CSC_ROTATION_STEPS   // 8..16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [CSC_PHASE_W-1:0]      in_phase,
  output logic                        out_valid,
  output logic signed [CSC_OUT_W-1:0] out_cosine,
  output logic signed [CSC_OUT_W-1:0] out_sine
);

  localparam int LATENCY = ROTATION_STEPS + 2;

  // stage ports: index 0 is the unregistered entry, index N the last rotation
  logic       vld [ROTATION_STEPS+1];
  csc_stage_t stg [ROTATION_STEPS+1];

  // fully pipelined: never refuses a beat
  assign busy = 1'b0;

  // Entry: quadrant from the top bits, residual angle scaled so 2^31 = 90 deg.
  assign vld[0]      = start & ~busy;
  assign stg[0].quad = csc_quad_t'(in_phase[CSC_PHASE_W-1 -: 2]);
  assign stg[0].x    = CSC_X_START;
  assign stg[0].y    = '0;
  assign stg[0].z    = $signed({{(CSC_Z_W-CSC_RES_W-17){1'b0}},
                                in_phase[CSC_RES_W-1:0], 17'b0});

  // One register stage per micro-rotation.
  for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_rot
    csc_rot_stage #(
      .STEP (i)
    ) u_rot (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vld[i]),
      .stg_i (stg[i]),
      .vld_o (vld[i+1]),
      .stg_o (stg[i+1])
    );
  end

  // Gain multiply and quadrant mapping.
  csc_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_i    (vld[ROTATION_STEPS]),
    .stg_i    (stg[ROTATION_STEPS]),
    .vld_o    (out_valid),
    .cosine_o (out_cosine),
    .sine_o   (out_sine)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // A result only comes out for a beat that was accepted at the pipeline input.
  `CSC_ASSERT_IMPLY(a_out_matches_accept, out_valid, $past(start && !busy, LATENCY), "result without matching input beat")

  // Outputs stay within [-1.0, +1.0].
  `CSC_ASSERT_NEVER(a_out_range, out_valid && (out_cosine > 17'sd32768 || out_cosine < -17'sd32768 || out_sine > 17'sd32768 || out_sine < -17'sd32768), "result magnitude above 1.0")

  // First-quadrant phases give non-negative cosine and sine.
  `CSC_ASSERT_IMPLY(a_quad0_sign, out_valid && ($past(in_phase[CSC_PHASE_W-1 -: 2], LATENCY) == CSC_QUAD_0), !out_cosine[CSC_OUT_W-1] && !out_sine[CSC_OUT_W-1], "wrong sign in first quadrant")

endmodule

[test/tb_cordic_sine_cosine_unit.sv]
// -----------------------------------------------------------------------------
// tb_cordic_sine_cosine_unit
// Self-checking bench for the pipelined CORDIC phase to cosine/sine converter.
// Phases go in through the start/busy command port. A built-in predictor runs
// the same sixteen rotation-mode steps, gain scaling and quadrant mapping in
// 64-bit integers. Every out_valid beat is compared with the oldest predicted
// pair. The run has directed corners, then random phases with and without
// input gaps, and one full drain in the middle of the traffic.
// -----------------------------------------------------------------------------
module tb_cordic_sine_cosine_unit
  import csc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS       = CSC_ROTATION_STEPS;
  localparam int PIPE_DEPTH  = STEPS + 2;     // accept edge to result edge
  localparam int CYCLE_LIMIT = 200_000;       // run limit for the watchdog

  // one predicted result beat
  typedef struct {
    logic [CSC_PHASE_W-1:0]      phase;
    logic signed [CSC_OUT_W-1:0] cosine;
    logic signed [CSC_OUT_W-1:0] sine;
  } cos_sin_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic [CSC_PHASE_W-1:0]      in_phase = '0;
  logic                        busy;
  logic                        out_valid;
  logic signed [CSC_OUT_W-1:0] out_cosine;
  logic signed [CSC_OUT_W-1:0] out_sine;

  cos_sin_t cos_sin_due_q[$];   // predicted beats, oldest first
  int       mismatch_count = 0;
  int       cycle_count = 0;
  bit       gaps_on = 1'b1;     // random sender idling enabled

  cordic_sine_cosine_unit #(
    .ROTATION_STEPS(STEPS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_phase  (in_phase),
    .out_valid (out_valid),
    .out_cosine(out_cosine),
    .out_sine  (out_sine)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // |v| >> 14, times the CORDIC gain correction, >> 16. Unsigned, full width.
  function automatic longint gain_scaled_mag(input longint v);
    longint m;
    m = (v < 0) ? -v : v;
    return ((m >>> 14) * longint'(CSC_GAIN)) >>> 16;
  endfunction

  function automatic void predict_cos_sin(input logic [CSC_PHASE_W-1:0] ph,
                                          output logic signed [CSC_OUT_W-1:0] c,
                                          output logic signed [CSC_OUT_W-1:0] s);
    csc_quad_t quad;
    longint    x, y, z, nx, ny, mx, my, cv, sv, step_angle;
    quad = csc_quad_t'(ph[15:14]);
    // residual: low 14 bits placed so that 2^31 is a quarter turn
    z = longint'(ph[CSC_RES_W-1:0]) << 17;
    x = longint'(CSC_X_START);
    y = 0;
    for (int i = 0; i < STEPS && i < CSC_TABLE_LEN; i++) begin
      step_angle = longint'(CSC_ATAN[i]);
      // >>> on a signed longint floors, as the datapath shifters do
      if (z < 0) begin
        z  = z + step_angle;
        nx = x + (y >>> i);
        ny = y - (x >>> i);
      end else begin
        z  = z - step_angle;
        nx = x - (y >>> i);
        ny = y + (x >>> i);
      end
      x = nx;
      y = ny;
    end
    mx = gain_scaled_mag(x);
    my = gain_scaled_mag(y);
    case (quad)
      CSC_QUAD_0: begin cv =  mx; sv =  my; end
      CSC_QUAD_1: begin cv = -my; sv =  mx; end
      CSC_QUAD_2: begin cv = -mx; sv = -my; end
      default:    begin cv =  my; sv = -mx; end
    endcase
    c = CSC_OUT_W'(cv);
    s = CSC_OUT_W'(sv);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    // print the first few in full, keep counting after that
    if (mismatch_count < 40)
      $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Outputs are sampled right at the edge, before the DUT's updates land,
  // so each beat is seen exactly in the cycle it is presented.
  always @(posedge clk) begin
    cos_sin_t due;
    if (rst_n && out_valid) begin
      if (cos_sin_due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat cos=%0d sin=%0d",
                                  out_cosine, out_sine));
      end else begin
        due = cos_sin_due_q.pop_front();
        if (out_cosine !== due.cosine)
          report_mismatch($sformatf("phase %h cosine got %0d want %0d",
                                    due.phase, out_cosine, due.cosine));
        if (out_sine !== due.sine)
          report_mismatch($sformatf("phase %h sine got %0d want %0d",
                                    due.phase, out_sine, due.sine));
      end
    end
  end

  // watchdog: a hang or a lost beat ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Present one phase and hold it until an edge with busy low takes it.
  // start stays high on return, so back-to-back calls keep the port full.
  task automatic send_phase(input logic [CSC_PHASE_W-1:0] ph);
    cos_sin_t due;
    start    <= 1'b1;
    in_phase <= ph;
    @(posedge clk);
    while (busy) @(posedge clk);
    due.phase = ph;
    predict_cos_sin(ph, due.cosine, due.sine);
    cos_sin_due_q.push_back(due);
  endtask

  // Random sender gap: ~20% of beats are followed by idle cycles, which
  // leaves the port idle in roughly 28% of cycles.
  task automatic maybe_gap();
    if (gaps_on && $urandom_range(99) < 20) begin
      start    <= 1'b0;
      in_phase <= CSC_PHASE_W'($urandom);
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    while (cos_sin_due_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Quadrant edges: zero residual in each quadrant (one component near full
  // scale, the other near zero), the step after it and the last step before each boundary.
  task automatic test_quadrant_corners();
    logic [CSC_PHASE_W-1:0] corners[$];
    corners = '{16'h0000, 16'h0001, 16'h3FFF, 16'h4000, 16'h4001, 16'h7FFF,
                16'h8000, 16'h8001, 16'hBFFF, 16'hC000, 16'hC001, 16'hFFFF};
    gaps_on = 1'b0;
    foreach (corners[k]) send_phase(corners[k]);
  endtask

  // Quadrant midpoints and a few scattered angles, with random gaps between beats.
  task automatic test_octant_points();
    logic [CSC_PHASE_W-1:0] points[$];
    points = '{16'h2000, 16'h6000, 16'hA000, 16'hE000,
               16'h5555, 16'hAAAA, 16'h0800, 16'h1234, 16'hEDCB};
    gaps_on = 1'b1;
    foreach (points[k]) begin
      send_phase(points[k]);
      maybe_gap();
    end
  endtask

  // Mostly uniform phases; about a third sit within 16 steps of a quadrant
  // edge, where the residual angle is tiny or nearly a quarter turn.
  task automatic test_random_phases(input int count, input bit with_gaps);
    logic [CSC_PHASE_W-1:0] ph;
    logic [CSC_RES_W-1:0]   near;
    gaps_on = with_gaps;
    repeat (count) begin
      if ($urandom_range(99) < 33) begin
        near = CSC_RES_W'($urandom_range(0, 15));
        if ($urandom_range(1)) near = ~near;
        ph = {2'($urandom_range(0, 3)), near};
      end else begin
        ph = CSC_PHASE_W'($urandom);
      end
      send_phase(ph);
      maybe_gap();
    end
  endtask

  // Sender stops until every result is out, then resumes from an empty pipe.
  task automatic test_drain_pause();
    test_random_phases(30, 1'b0);
    drain_pipeline();
    test_random_phases(30, 1'b1);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_quadrant_corners();
    test_octant_points();
    test_random_phases(500, 1'b1);
    test_random_phases(350, 1'b0);    // long stretch, one beat per clock
    test_drain_pause();
    test_random_phases(480, 1'b1);

    drain_pipeline();
    repeat (PIPE_DEPTH + 4) @(posedge clk);   // catch any stray extra beat
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/csc_pkg.sv
design/csc_rot_stage.sv
design/csc_scale.sv
design/cordic_sine_cosine_unit.sv
test/tb_cordic_sine_cosine_unit.sv
